// ----- sv/rvpi_pkg.sv -----
// Shared types and constants of the ramped velocity PI controller.
package rvpi_pkg;

  // Configuration write port widths
  localparam int unsigned CfgIdxW  = 3;
  localparam int unsigned CfgDataW = 32;

  // Serial step counter and the last step of each serial phase
  localparam int unsigned CntW = 5;
  localparam logic [CntW-1:0] MUL1_LAST = 5'd20;  // 21-bit signed speed operands
  localparam logic [CntW-1:0] MUL2_LAST = 5'd31;  // 32-bit signed error operand
  localparam logic [CntW-1:0] DIV_LAST  = 5'd18;  // 19-bit filter dividend

  // Filter divisor (0.2/0.8 blend computed as a divide by five)
  localparam logic [3:0] FILT_DIV = 4'd5;

  // Register indexes of the configuration port
  typedef enum logic [CfgIdxW-1:0] {
    REG_KP_GAIN      = 3'd0,
    REG_KI_PERIOD    = 3'd1,
    REG_INV_SPD_MAX  = 3'd2,
    REG_DUTY_LIM_HI  = 3'd3,
    REG_DUTY_LIM_LO  = 3'd4,
    REG_SPD_DEADBAND = 3'd5,
    REG_RAMP_STEP    = 3'd6
  } cfg_reg_e;

  // Input item
  typedef struct packed {
    logic signed [19:0] target_speed;
    logic signed [19:0] measured_speed;
    logic               ramp_enable;
    logic               restart;
  } in_item_t;

  // Result item
  typedef struct packed {
    logic        [15:0] duty;
    logic               forward;
    logic               drive_enable;
    logic signed [19:0] ramped_reference;
  } out_item_t;

endpackage

// ----- sv/ramped_velocity_pi_controller_core.sv -----
// Ramped velocity PI controller with back-calculation anti-windup (top level).
//
// Usage:
//   Input channel (in_valid_i/in_ready_o/in_data_i) takes one control tick:
//   target and measured speed, ramp enable and restart. The output channel
//   (out_valid_o/out_ready_i/out_data_o) returns one item per tick: duty,
//   direction, drive enable and the current ramp value.
//   Configuration registers are written through cfg_we_i/cfg_index_i/cfg_data_i;
//   the user must do so only while no tick is in flight; the block does not check.
// Timing:
//   A new tick is taken only once the previous one has finished; the computation
//   runs through the serial shift-add multipliers (21 steps for speed scaling,
//   32 steps for the gain products, two lanes each) and the bit-serial divide
//   by five of the output filter (19 steps).
// Reset:
//   Configuration registers return to their defaults; integrator, filter and ramp clear.
// Stall:
//   A finished result waits in the output register; the next tick is taken
//   and computed meanwhile, and holds at its last step until the register frees.
module ramped_velocity_pi_controller_core
  import rvpi_pkg::*;
(
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_ready_o,
  input  in_item_t            in_data_i,
  output logic                out_valid_o,
  input  logic                out_ready_i,
  output out_item_t           out_data_o,
  input  logic                cfg_we_i,
  input  logic [CfgIdxW-1:0]  cfg_index_i,
  input  logic [CfgDataW-1:0] cfg_data_i
);

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_RAMP,
    ST_DIR,
    ST_MUL1,
    ST_ERR,
    ST_MUL2,
    ST_SUM,
    ST_ADD,
    ST_CLAMP,
    ST_INTEG,
    ST_DIV,
    ST_DONE
  } state_e;

  // Saturate a 34-bit signed value to 32 bits
  function automatic logic [31:0] sat_err(input logic [33:0] x);
    logic [31:0] r;
    if (x[33:31] == 3'b000 || x[33:31] == 3'b111) begin
      r = x[31:0];
    end else if (x[33]) begin
      r = 32'h8000_0000;
    end else begin
      r = 32'h7FFF_FFFF;
    end
    return r;
  endfunction

  // Saturate a 43-bit signed value to 32 bits
  function automatic logic [31:0] sat_int(input logic [42:0] x);
    logic [31:0] r;
    if (x[42:31] == 12'h000 || x[42:31] == 12'hFFF) begin
      r = x[31:0];
    end else if (x[42]) begin
      r = 32'h8000_0000;
    end else begin
      r = 32'h7FFF_FFFF;
    end
    return r;
  endfunction

  // Control and architectural state
  state_e          state_q;
  logic [CntW-1:0] cnt_q;
  logic            out_valid_q;
  out_item_t       out_q;
  logic [23:0]     kp_q;
  logic [31:0]     ki_q;
  logic [31:0]     isp_q;
  logic [15:0]     lim_hi_q;
  logic [15:0]     lim_lo_q;
  logic [18:0]     deadband_q;
  logic [18:0]     ramp_step_q;
  logic [31:0]     integ_q;
  logic [16:0]     filt_q;
  logic [19:0]     ramp_q;

  // Datapath registers
  logic [19:0] tgt_q;
  logic [19:0] meas_q;
  logic        ramp_en_q;
  logic [19:0] ref_q;
  logic        fwd_q;
  logic [20:0] ref_abs_q;
  logic [20:0] meas_adj_q;
  logic        en_q;
  logic [31:0] s0_q, s1_q;
  logic [63:0] m0_q, m1_q;
  logic [63:0] acc0_q, acc1_q;
  logic [30:0] rn_q;
  logic [42:0] uo_part_q;
  logic [42:0] ui_q;
  logic [42:0] uo_raw_q;
  logic [16:0] uo_sat_q;
  logic [18:0] div_q;
  logic [2:0]  rem_q;

  logic in_xfer;
  logic out_free;
  assign in_xfer  = in_valid_i && (state_q == ST_IDLE);
  assign out_free = !out_valid_q || out_ready_i;

  assign in_ready_o  = (state_q == ST_IDLE);
  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

  // Ramp generator step
  logic [20:0] ramp_ext, tgt_ext, step_ext, step_neg, ramp_diff, ramp_sum;
  logic [19:0] ramp_nxt;
  always_comb begin
    ramp_ext  = {ramp_q[19], ramp_q};
    tgt_ext   = {tgt_q[19], tgt_q};
    step_ext  = {2'b00, ramp_step_q};
    step_neg  = 21'd0 - step_ext;
    ramp_diff = tgt_ext - ramp_ext;
    priority if ($signed(ramp_diff) > $signed(step_ext)) begin
      ramp_sum = ramp_ext + step_ext;
    end else if ($signed(ramp_diff) < $signed(step_neg)) begin
      ramp_sum = ramp_ext - step_ext;
    end else begin
      ramp_sum = tgt_ext;
    end
    ramp_nxt = ramp_sum[19:0];
  end

  // Direction: negate both speeds for a negative reference
  logic [20:0] ref_ext, meas_ext, ref_abs_d, meas_adj_d;
  always_comb begin
    ref_ext  = {ref_q[19], ref_q};
    meas_ext = {meas_q[19], meas_q};
    if (ref_q[19]) begin
      ref_abs_d  = 21'd0 - ref_ext;
      meas_adj_d = 21'd0 - meas_ext;
    end else begin
      ref_abs_d  = ref_ext;
      meas_adj_d = meas_ext;
    end
  end

  // Serial shift-add lanes; the last step weights the sign bit negatively
  logic        mul_last;
  logic [63:0] term0, term1, acc0_d, acc1_d;
  always_comb begin
    mul_last = (state_q == ST_MUL1) ? (cnt_q == MUL1_LAST) : (cnt_q == MUL2_LAST);
    term0    = s0_q[0] ? m0_q : 64'd0;
    term1    = s1_q[0] ? m1_q : 64'd0;
    acc0_d   = mul_last ? (acc0_q - term0) : (acc0_q + term0);
    acc1_d   = mul_last ? (acc1_q - term1) : (acc1_q + term1);
  end

  // Speed error from the scaled speeds, and drive enable
  logic [30:0] rn;
  logic [31:0] an;
  logic [33:0] err_wide;
  logic [31:0] err;
  logic [20:0] db_ext;
  logic        en_d;
  always_comb begin
    rn       = acc0_q[50:20];
    an       = acc1_q[51:20];
    err_wide = {3'b000, rn} - {{2{an[31]}}, an};
    err      = sat_err(err_wide);
    db_ext   = {2'b00, deadband_q};
    en_d     = !(($signed(ref_abs_q) < $signed(db_ext)) &&
                 ($signed(meas_adj_q) < $signed(db_ext)));
  end

  // Output sum, clamp and back-calculated integrator
  logic [39:0] up, delta;
  logic [42:0] uo_part_d, ui_d;
  logic [42:0] hi_ext, lo_ext;
  logic [16:0] uo_sat_d;
  logic [31:0] integ_new;
  logic [18:0] dividend;
  always_comb begin
    up        = acc0_q[55:16];
    delta     = acc1_q[63:24];
    uo_part_d = {12'd0, rn_q} + {{3{up[39]}}, up};
    ui_d      = {{11{integ_q[31]}}, integ_q} + {{3{delta[39]}}, delta};
    hi_ext    = {26'd0, lim_hi_q, 1'b0};
    lo_ext    = {26'd0, lim_lo_q, 1'b0};
    priority if ($signed(uo_raw_q) > $signed(hi_ext)) begin
      uo_sat_d = hi_ext[16:0];
    end else if ($signed(uo_raw_q) < $signed(lo_ext)) begin
      uo_sat_d = lo_ext[16:0];
    end else begin
      uo_sat_d = uo_raw_q[16:0];
    end
    integ_new = sat_int({26'd0, uo_sat_q} - uo_part_q);
    dividend  = {2'b00, filt_q} + {uo_sat_q, 2'b00} + 19'd2;
  end

  // Restoring divide by five, one quotient bit per step
  logic [3:0]  rem_try;
  logic        q_bit;
  logic [2:0]  rem_d;
  logic [18:0] div_d;
  always_comb begin
    rem_try = {rem_q, div_q[18]};
    q_bit   = (rem_try >= FILT_DIV);
    rem_d   = q_bit ? 3'(rem_try - FILT_DIV) : rem_try[2:0];
    div_d   = {div_q[17:0], q_bit};
  end

  // Result fields
  out_item_t out_d;
  always_comb begin
    out_d.duty             = en_q ? div_q[16:1] : 16'd0;
    out_d.forward          = en_q ? fwd_q : 1'b1;
    out_d.drive_enable     = en_q;
    out_d.ramped_reference = ramp_q;
  end

  // Sequencer, configuration registers and loop state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      cnt_q       <= '0;
      out_valid_q <= 1'b0;
      out_q       <= '0;
      kp_q        <= 24'd65536;
      ki_q        <= '0;
      isp_q       <= '0;
      lim_hi_q    <= 16'd32768;
      lim_lo_q    <= '0;
      deadband_q  <= '0;
      ramp_step_q <= '0;
      integ_q     <= '0;
      filt_q      <= '0;
      ramp_q      <= '0;
    end else begin
      if (cfg_we_i) begin
        unique case (cfg_reg_e'(cfg_index_i))
          REG_KP_GAIN:      kp_q        <= cfg_data_i[23:0];
          REG_KI_PERIOD:    ki_q        <= cfg_data_i;
          REG_INV_SPD_MAX:  isp_q       <= cfg_data_i;
          REG_DUTY_LIM_HI:  lim_hi_q    <= cfg_data_i[15:0];
          REG_DUTY_LIM_LO:  lim_lo_q    <= cfg_data_i[15:0];
          REG_SPD_DEADBAND: deadband_q  <= cfg_data_i[18:0];
          REG_RAMP_STEP:    ramp_step_q <= cfg_data_i[18:0];
          default: ;
        endcase
      end

      // Result leaves; in ST_DONE the load of the next result decides instead
      if (out_valid_q && out_ready_i && state_q != ST_DONE) begin
        out_valid_q <= 1'b0;
      end

      unique case (state_q)
        ST_IDLE: begin
          if (in_xfer) begin
            if (in_data_i.restart) begin
              integ_q <= '0;
              filt_q  <= '0;
              ramp_q  <= '0;
            end
            state_q <= ST_RAMP;
          end
        end
        ST_RAMP: begin
          if (ramp_en_q) begin
            ramp_q <= ramp_nxt;
          end
          state_q <= ST_DIR;
        end
        ST_DIR: begin
          cnt_q   <= '0;
          state_q <= ST_MUL1;
        end
        ST_MUL1: begin
          if (cnt_q == MUL1_LAST) begin
            cnt_q   <= '0;
            state_q <= ST_ERR;
          end else begin
            cnt_q <= cnt_q + 5'd1;
          end
        end
        ST_ERR: begin
          cnt_q   <= '0;
          state_q <= ST_MUL2;
        end
        ST_MUL2: begin
          if (cnt_q == MUL2_LAST) begin
            cnt_q   <= '0;
            state_q <= ST_SUM;
          end else begin
            cnt_q <= cnt_q + 5'd1;
          end
        end
        ST_SUM:   state_q <= ST_ADD;
        ST_ADD:   state_q <= ST_CLAMP;
        ST_CLAMP: state_q <= ST_INTEG;
        ST_INTEG: begin
          integ_q <= en_q ? integ_new : 32'd0;
          cnt_q   <= '0;
          state_q <= ST_DIV;
        end
        ST_DIV: begin
          if (cnt_q == DIV_LAST) begin
            cnt_q   <= '0;
            state_q <= ST_DONE;
          end else begin
            cnt_q <= cnt_q + 5'd1;
          end
        end
        ST_DONE: begin
          if (out_free) begin
            filt_q      <= div_q[16:0];
            out_q       <= out_d;
            out_valid_q <= 1'b1;
            state_q     <= ST_IDLE;
          end
        end
        default: state_q <= ST_IDLE;
      endcase
    end
  end

  // Datapath registers
  always_ff @(posedge clk_i) begin
    unique case (state_q)
      ST_IDLE: begin
        if (in_xfer) begin
          tgt_q     <= in_data_i.target_speed;
          meas_q    <= in_data_i.measured_speed;
          ramp_en_q <= in_data_i.ramp_enable;
        end
      end
      ST_RAMP: begin
        ref_q <= ramp_en_q ? ramp_nxt : tgt_q;
      end
      ST_DIR: begin
        fwd_q      <= !ref_q[19];
        ref_abs_q  <= ref_abs_d;
        meas_adj_q <= meas_adj_d;
        s0_q       <= {{11{ref_abs_d[20]}}, ref_abs_d};
        s1_q       <= {{11{meas_adj_d[20]}}, meas_adj_d};
        m0_q       <= {32'd0, isp_q};
        m1_q       <= {32'd0, isp_q};
        acc0_q     <= '0;
        acc1_q     <= '0;
      end
      ST_MUL1, ST_MUL2: begin
        s0_q   <= {1'b0, s0_q[31:1]};
        s1_q   <= {1'b0, s1_q[31:1]};
        m0_q   <= {m0_q[62:0], 1'b0};
        m1_q   <= {m1_q[62:0], 1'b0};
        acc0_q <= acc0_d;
        acc1_q <= acc1_d;
      end
      ST_ERR: begin
        rn_q   <= rn;
        en_q   <= en_d;
        s0_q   <= err;
        s1_q   <= err;
        m0_q   <= {40'd0, kp_q};
        m1_q   <= {32'd0, ki_q};
        acc0_q <= '0;
        acc1_q <= '0;
      end
      ST_SUM: begin
        uo_part_q <= uo_part_d;
        ui_q      <= ui_d;
      end
      ST_ADD: begin
        uo_raw_q <= uo_part_q + ui_q;
      end
      ST_CLAMP: begin
        uo_sat_q <= uo_sat_d;
      end
      ST_INTEG: begin
        div_q <= dividend;
        rem_q <= '0;
      end
      ST_DIV: begin
        div_q <= div_d;
        rem_q <= rem_d;
      end
      ST_DONE: ;
      default: ;
    endcase
  end

endmodule
